[hw/rtl/sgm_pkg.sv]
// Package for the Sobel RGB gradient magnitude unit.
// Holds widths, register indexes and the types shared by front, queue and back.
// No dependencies.
package sgm_pkg;

  localparam int MaxWidth  = 2048;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int WidthW    = 12;
  localparam int HeightW   = 16;
  localparam int CmpW      = (ColW + 1 > WidthW) ? ColW + 1 : WidthW;
  localparam int MinDim    = 3;

  localparam int CfgW      = 16;
  localparam int CfgIdxW   = 1;
  localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;

  localparam int ChanW     = 8;
  localparam int NumChan   = 3;
  localparam int PixW      = ChanW * NumChan;
  localparam int GradW     = ChanW + 3;
  localparam int SqW       = 2 * ChanW + 5;
  localparam int RemW      = 2 * ChanW;
  localparam int RootW     = RemW + 1;
  localparam int IterW     = $clog2(ChanW);
  localparam int MagMax    = (1 << ChanW) - 1;
  localparam int SatLimit  = MagMax * MagMax;

  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  typedef logic [PixW-1:0] pix_t;
  typedef logic signed [GradW-1:0] grad_t;

  typedef struct packed {
    grad_t [NumChan-1:0] gx;
    grad_t [NumChan-1:0] gy;
    logic                frame_end;
  } item_t;

  typedef struct packed {
    logic             empty;
    logic [QCntW-1:0] cnt;
  } q_stat_t;

endpackage

[hw/rtl/sgm_ram.sv]
// Generic simple dual-port RAM with registered read.
// One write port, one read port; no dependencies.
module sgm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/sgm_front.sv]
// Front of the Sobel unit: pixel intake, raster counters, line stores, 3x3 window.
// Forms per-channel gx/gy and hands them to the queue. Uses sgm_pkg and sgm_ram.
module sgm_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [sgm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sgm_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                   push,
  output logic                   full,
  input  logic [sgm_pkg::PixW-1:0]    pix_i,
  input  sgm_pkg::q_stat_t       q_stat_i,
  output logic                   q_push_o,
  output sgm_pkg::item_t         q_item_o
);
  import sgm_pkg::*;

  logic [WidthW-1:0]  fw_q;
  logic [HeightW-1:0] fh_q;
  logic [ColW-1:0]    col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;

  logic [CmpW-1:0]    fw_ext, w_eff, w_last;
  logic [HeightW-1:0] h_eff, h_last;
  logic               last_col, last_row, has_res, accept;
  logic [QCntW:0]     q_load;

  logic               s1_v_q, s1_res_q, s1_end_q;
  pix_t               s1_px_q;
  logic [ColW-1:0]    s1_col_q;
  pix_t               rd_a, rd_b;
  pix_t               win_q [6];
  pix_t               tap [3][3];
  grad_t              ch [3][3];
  item_t              item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= WidthW'(640);
      fh_q <= HeightW'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth:  fw_q <= cfg_wdata_i[WidthW-1:0];
        RegHeight: fh_q <= cfg_wdata_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = CmpW'(fw_q);
    if (fw_ext < CmpW'(MinDim)) begin
      w_eff = CmpW'(MinDim);
    end else if (fw_ext > CmpW'(MaxWidth)) begin
      w_eff = CmpW'(MaxWidth);
    end else begin
      w_eff = fw_ext;
    end
    w_last   = w_eff - CmpW'(1);
    h_eff    = (fh_q < HeightW'(MinDim)) ? HeightW'(MinDim) : fh_q;
    h_last   = h_eff - HeightW'(1);
    last_col = CmpW'(col_q) >= w_last;
    last_row = row_q >= h_last;
    has_res  = (row_q >= HeightW'(2)) && (col_q >= ColW'(2));
  end

  assign q_load = (QCntW+1)'(q_stat_i.cnt) + (QCntW+1)'(s1_v_q & s1_res_q);
  assign full   = q_load >= (QCntW+1)'(QDepth);
  assign accept = push & ~full;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + HeightW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_v_q   <= 1'b0;
      s1_res_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      s1_v_q   <= accept;
      s1_res_q <= accept & has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q  <= pix_i;
      s1_col_q <= col_q;
      s1_end_q <= last_col & last_row;
    end
  end

  sgm_ram #(.Width(PixW), .Depth(MaxWidth)) u_row_a (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_a)
  );

  sgm_ram #(.Width(PixW), .Depth(MaxWidth)) u_row_b (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_col_q),
    .wdata_i (rd_a),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_v_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= rd_b;
      win_q[2] <= win_q[3];
      win_q[3] <= rd_a;
      win_q[4] <= win_q[5];
      win_q[5] <= s1_px_q;
    end
  end

  always_comb begin
    tap[0][0] = win_q[0];
    tap[0][1] = win_q[1];
    tap[0][2] = rd_b;
    tap[1][0] = win_q[2];
    tap[1][1] = win_q[3];
    tap[1][2] = rd_a;
    tap[2][0] = win_q[4];
    tap[2][1] = win_q[5];
    tap[2][2] = s1_px_q;
    item.frame_end = s1_end_q;
    for (int c = 0; c < NumChan; c++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          ch[r][k] = $signed({{(GradW-ChanW){1'b0}}, tap[r][k][ChanW*c +: ChanW]});
        end
      end
      item.gx[c] = (ch[0][2] - ch[0][0]) + ((ch[1][2] - ch[1][0]) <<< 1)
                 + (ch[2][2] - ch[2][0]);
      item.gy[c] = (ch[0][0] - ch[2][0]) + ((ch[0][1] - ch[2][1]) <<< 1)
                 + (ch[0][2] - ch[2][2]);
    end
  end

  assign q_push_o = s1_v_q & s1_res_q;
  assign q_item_o = item;

endmodule

[hw/rtl/sgm_queue.sv]
// Short register queue of gradient transactions between front and back.
// Uses sgm_pkg.
module sgm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sgm_pkg::item_t   item_i,
  input  logic             pop_i,
  output sgm_pkg::item_t   item_o,
  output sgm_pkg::q_stat_t stat_o
);
  import sgm_pkg::*;

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;

  function automatic logic [QPtrW-1:0] bump(logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= bump(wr_q);
      end
      if (pop_i) begin
        rd_q <= bump(rd_q);
      end
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_q];
  assign stat_o.cnt   = cnt_q;
  assign stat_o.empty = (cnt_q == '0);

endmodule

[hw/rtl/sgm_back.sv]
// Back of the Sobel unit: squares, bit-serial integer square root, saturation.
// Holds the result register seen on the output ports. Uses sgm_pkg.
module sgm_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sgm_pkg::q_stat_t       q_stat_i,
  input  sgm_pkg::item_t         q_item_i,
  output logic                   q_pop_o,
  input  logic                   pop,
  output logic                   empty,
  output logic [sgm_pkg::ChanW-1:0] mag_blue_o,
  output logic [sgm_pkg::ChanW-1:0] mag_green_o,
  output logic [sgm_pkg::ChanW-1:0] mag_red_o,
  output logic                   frame_end_o
);
  import sgm_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSquare = 2'd1;
  localparam logic [1:0] StRoot   = 2'd2;
  localparam logic [1:0] StOut    = 2'd3;

  logic [1:0]        st_q, st_d;
  grad_t             gx_q [NumChan];
  grad_t             gy_q [NumChan];
  logic              end_q;
  logic [SqW-1:0]    sq_q [NumChan];
  logic [RemW-1:0]   rem_q [NumChan];
  logic [RootW-1:0]  root_q [NumChan];
  logic [IterW-1:0]  k_q;
  logic              sat;
  logic              out_v_q;
  logic [ChanW-1:0]  mag_q [NumChan];
  logic              fe_q;
  logic              out_free;

  logic signed [2*GradW-1:0] pxx [NumChan];
  logic signed [2*GradW-1:0] pyy [NumChan];
  logic [SqW-1:0]    sq [NumChan];
  logic [RootW-1:0]  bitv, trial [NumChan];

  assign out_free = ~out_v_q | pop;
  assign q_pop_o  = (st_q == StIdle) & ~q_stat_i.empty;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:   if (!q_stat_i.empty) st_d = StSquare;
      StSquare: st_d = StRoot;
      StRoot:   if (k_q == '0) st_d = StOut;
      StOut:    if (out_free) st_d = StIdle;
      default:  st_d = StIdle;
    endcase
  end

  always_comb begin
    sat  = 1'b0;
    bitv = RootW'(1) << {k_q, 1'b0};
    for (int c = 0; c < NumChan; c++) begin
      pxx[c]   = gx_q[c] * gx_q[c];
      pyy[c]   = gy_q[c] * gy_q[c];
      sq[c]    = SqW'($unsigned(pxx[c])) + SqW'($unsigned(pyy[c]));
      trial[c] = root_q[c] + bitv;
      if (sq_q[c] > SqW'(SatLimit)) begin
        sat = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StOut && out_free) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        for (int c = 0; c < NumChan; c++) begin
          gx_q[c] <= $signed(q_item_i.gx[c]);
          gy_q[c] <= $signed(q_item_i.gy[c]);
        end
        end_q <= q_item_i.frame_end;
      end
      StSquare: begin
        for (int c = 0; c < NumChan; c++) begin
          sq_q[c]   <= sq[c];
          rem_q[c]  <= sq[c][RemW-1:0];
          root_q[c] <= '0;
        end
        k_q <= IterW'(ChanW - 1);
      end
      StRoot: begin
        for (int c = 0; c < NumChan; c++) begin
          if ({1'b0, rem_q[c]} >= trial[c]) begin
            rem_q[c]  <= rem_q[c] - trial[c][RemW-1:0];
            root_q[c] <= (root_q[c] >> 1) + bitv;
          end else begin
            root_q[c] <= root_q[c] >> 1;
          end
        end
        k_q <= k_q - IterW'(1);
      end
      StOut: begin
        if (out_free) begin
          for (int c = 0; c < NumChan; c++) begin
            mag_q[c] <= sat ? ChanW'(MagMax) : root_q[c][ChanW-1:0];
          end
          fe_q <= end_q;
        end
      end
      default: ;
    endcase
  end

  assign empty       = ~out_v_q;
  assign mag_blue_o  = mag_q[0];
  assign mag_green_o = mag_q[1];
  assign mag_red_o   = mag_q[2];
  assign frame_end_o = fe_q;

endmodule

[hw/rtl/sobel_gradient_magnitude_rgb_unit.sv]
// Top level of the Sobel 3x3 RGB gradient magnitude unit.
// Instantiates sgm_front, sgm_queue and sgm_back; uses sgm_pkg.
//
//   channel   | handshake              | payload
//   ----------+------------------------+---------------------------------------
//   pixel in  | push / full            | in_blue_i, in_green_i, in_red_i
//   result    | pop / empty            | mag_blue_o, mag_green_o, mag_red_o,
//             |                        | frame_end_o
//   config    | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// The front takes one pixel per cycle while the gradient queue (4 entries) has room;
// border pixels never enter the queue. The back handles one output pixel at a time,
// in steps: dequeue, square, eight root iterations (one result bit each), write-out.
// A result waiting on pop holds the back in its write-out step; the queue then fills
// and raises full. Reset clears counters, window and queue; line stores are not cleared.
module sobel_gradient_magnitude_rgb_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sgm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sgm_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic [sgm_pkg::ChanW-1:0]   in_blue_i,
  input  logic [sgm_pkg::ChanW-1:0]   in_green_i,
  input  logic [sgm_pkg::ChanW-1:0]   in_red_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [sgm_pkg::ChanW-1:0]   mag_blue_o,
  output logic [sgm_pkg::ChanW-1:0]   mag_green_o,
  output logic [sgm_pkg::ChanW-1:0]   mag_red_o,
  output logic                        frame_end_o
);
  import sgm_pkg::*;

  logic    q_push, q_pop;
  item_t   q_in, q_out;
  q_stat_t q_stat;
  pix_t    pix;

  assign pix = {in_red_i, in_green_i, in_blue_i};

  sgm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .pix_i       (pix),
    .q_stat_i    (q_stat),
    .q_push_o    (q_push),
    .q_item_o    (q_in)
  );

  sgm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .pop_i  (q_pop),
    .item_o (q_out),
    .stat_o (q_stat)
  );

  sgm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .mag_blue_o  (mag_blue_o),
    .mag_green_o (mag_green_o),
    .mag_red_o   (mag_red_o),
    .frame_end_o (frame_end_o)
  );

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.cnt <= QCntW'(QDepth))
    else $error("gradient queue over capacity");

  a_q_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_stat.cnt < QCntW'(QDepth)))
    else $error("gradient queue written while full");

  a_q_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("gradient queue read while empty");

  a_full_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.cnt == QCntW'(QDepth)) |-> full)
    else $error("input open while gradient queue is full");

endmodule
